// ===== design/sls_pkg.sv =====
// ============================================================================
// sls_pkg
// Shared types, constants and helpers for the status LED sequencer.
// ============================================================================
`default_nettype none

package sls_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int LEVEL_W        = 7;
    localparam int CFG_IDX_W      = 3;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ON_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAP_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BATTERY   = 3'd5;

    // reset values of the registers
    localparam logic [CFG_W-1:0]   START_DELAY_RST   = 16'd250;
    localparam logic [CFG_W-1:0]   STEP_ON_TIME_RST  = 16'd250;
    localparam logic [CFG_W-1:0]   STEP_GAP_TIME_RST = 16'd20;
    localparam logic [CFG_W-1:0]   PULSE_TIME_RST    = 16'd120;
    localparam logic [CFG_W-1:0]   BLINK_PERIOD_RST  = 16'd300;
    localparam logic [LEVEL_W-1:0] LOW_BATTERY_RST   = 7'd30;

    // self-test sequence: odd phases 1 to 7 light an LED, even phases 2 to 8 are gaps
    typedef enum logic [3:0] {
        PH_WAIT      = 4'd0,
        PH_LINK_ON   = 4'd1,
        PH_LINK_GAP  = 4'd2,
        PH_COLL_ON   = 4'd3,
        PH_COLL_GAP  = 4'd4,
        PH_SEND_ON   = 4'd5,
        PH_SEND_GAP  = 4'd6,
        PH_POWER_ON  = 4'd7,
        PH_POWER_GAP = 4'd8,
        PH_DONE      = 4'd9
    } phase_t;

    // input tick, last field in the lowest bit
    typedef struct packed {
        logic [LEVEL_W-1:0] battery_level;
        logic               pulse_request;
        logic               pretest_mode;
        logic               collect_done;
        logic               erasing;
        logic               history_sending;
        logic               link_connected;
    } tick_t;

    // result, last field in the lowest bit
    typedef struct packed {
        logic pulse_ack;
        logic led_power;
        logic led_send;
        logic led_collect;
        logic led_link;
    } led_t;

    // Land on phase p, or on the first later phase of nonzero length.
    function automatic phase_t enter_phase(logic [3:0] p, logic on_zero, logic gap_zero);
        logic [3:0] q;
        logic       p_zero;
        logic       q_zero;
        phase_t     res;
        q      = p + 4'd1;
        p_zero = p[0] ? on_zero : gap_zero;
        q_zero = q[0] ? on_zero : gap_zero;
        if (p >= 4'(PH_DONE)) begin
            res = PH_DONE;
        end else if (!p_zero) begin
            res = phase_t'(p);
        end else if (q <= 4'(PH_POWER_GAP) && !q_zero) begin
            res = phase_t'(q);
        end else begin
            res = PH_DONE;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/status_led_sequencer.sv =====
// Path: an accepted item goes to the input register, then to the result register that drives m_tdata.
// Throughput: one tick item per cycle while m_tready does not stall the result register; the phase,
// pulse and blink counters update in a single pass between the input register and the result register.
// Reset: timers, phase and LED state clear, registers take their reset values,
// both pipeline registers empty; no clearing pass is needed.
// ============================================================================
// status_led_sequencer
// Self-test sequencing and status LED drive, one result per 1 ms tick.
// ============================================================================
`default_nettype none

module status_led_sequencer #(
    parameter int TIMER_BITS = sls_pkg::TIMER_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // config write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sls_pkg::CFG_W-1:0]        cfg_data,
    // tdata: link_connected, history_sending, erasing, collect_done,
    //        pretest_mode, pulse_request, battery_level[6:0], 3 zero bits
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sls_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tdata: led_link, led_collect, led_send, led_power, pulse_ack, 3 zero bits
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sls_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import sls_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // configuration registers
    logic [CFG_W-1:0]   start_delay_reg;
    logic [CFG_W-1:0]   step_on_time_reg;
    logic [CFG_W-1:0]   step_gap_time_reg;
    logic [CFG_W-1:0]   pulse_time_reg;
    logic [CFG_W-1:0]   blink_period_reg;
    logic [LEVEL_W-1:0] low_battery_reg;

    // pipeline
    logic   in_valid_reg;
    tick_t  in_data_reg;
    logic   out_valid_reg;
    led_t   out_data_reg;
    logic   advance;

    // sequencer state
    phase_t                phase_reg,       phase_next;
    logic [TIMER_BITS-1:0] phase_timer_reg, phase_timer_next;
    logic [CFG_W-1:0]      pulse_timer_reg, pulse_timer_next;
    logic [TIMER_BITS-1:0] blink_timer_reg, blink_timer_next;
    logic                  power_level_reg, power_level_next;
    led_t                  result_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_TDATA_W'(out_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg   <= START_DELAY_RST;
            step_on_time_reg  <= STEP_ON_TIME_RST;
            step_gap_time_reg <= STEP_GAP_TIME_RST;
            pulse_time_reg    <= PULSE_TIME_RST;
            blink_period_reg  <= BLINK_PERIOD_RST;
            low_battery_reg   <= LOW_BATTERY_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_DELAY:   start_delay_reg   <= cfg_data;
                REG_STEP_ON_TIME:  step_on_time_reg  <= cfg_data;
                REG_STEP_GAP_TIME: step_gap_time_reg <= cfg_data;
                REG_PULSE_TIME:    pulse_time_reg    <= cfg_data;
                REG_BLINK_PERIOD:  blink_period_reg  <= cfg_data;
                REG_LOW_BATTERY:   low_battery_reg   <= cfg_data[LEVEL_W-1:0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= tick_t'(s_tdata[$bits(tick_t)-1:0]);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            phase_timer_reg <= '0;
            pulse_timer_reg <= '0;
            blink_timer_reg <= '0;
            power_level_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            phase_timer_reg <= phase_timer_next;
            pulse_timer_reg <= pulse_timer_next;
            blink_timer_reg <= blink_timer_next;
            power_level_reg <= power_level_next;
        end
    end

    // one tick of work
    always_comb
    begin
        logic                  on_zero;
        logic                  gap_zero;
        phase_t                ph;
        logic [TIMER_BITS-1:0] pt;
        logic [TIMER_BITS-1:0] bt;
        logic                  pw;
        logic [CFG_W-1:0]      pu;
        logic [CFG_W-1:0]      step_len;

        on_zero  = (step_on_time_reg == '0);
        gap_zero = (step_gap_time_reg == '0);
        ph       = (phase_reg > PH_DONE) ? PH_DONE : phase_reg;
        pt       = phase_timer_reg;
        bt       = blink_timer_reg;
        pw       = power_level_reg;
        pu       = pulse_timer_reg;
        step_len = '0;
        result_next = '0;

        // start wait
        if (ph == PH_WAIT)
        begin
            if (CMP_W'(pt) >= CMP_W'(start_delay_reg))
            begin
                ph = enter_phase(4'(PH_LINK_ON), on_zero, gap_zero);
                pt = '0;
                if (ph == PH_DONE)
                begin
                    bt = '0;
                    pw = 1'b0;
                end
            end
            else if (pt != TIMER_MAX)
            begin
                pt = pt + 1'b1;
            end
        end

        if (ph != PH_WAIT && ph != PH_DONE)
        begin
            result_next.led_link    = (ph == PH_LINK_ON);
            result_next.led_collect = (ph == PH_COLL_ON);
            result_next.led_send    = (ph == PH_SEND_ON);
            result_next.led_power   = (ph == PH_POWER_ON);
            step_len = ph[0] ? step_on_time_reg : step_gap_time_reg;
            if (pt != TIMER_MAX)
            begin
                pt = pt + 1'b1;
            end
            if (CMP_W'(pt) >= CMP_W'(step_len))
            begin
                ph = enter_phase(4'(ph) + 4'd1, on_zero, gap_zero);
                pt = '0;
                if (ph == PH_DONE)
                begin
                    bt = '0;
                    pw = 1'b0;
                end
            end
        end
        else
        begin
            result_next.led_link = in_data_reg.link_connected;
            result_next.led_send = in_data_reg.history_sending | in_data_reg.erasing;
            if (in_data_reg.pulse_request)
            begin
                result_next.pulse_ack = 1'b1;
                pu = pulse_time_reg;
            end
            result_next.led_collect = (pu != '0) ||
                                      (in_data_reg.collect_done && !in_data_reg.pretest_mode);
            if (ph == PH_WAIT || !(in_data_reg.battery_level < low_battery_reg))
            begin
                pw = 1'b0;
                bt = '0;
            end
            else
            begin
                if (bt != TIMER_MAX)
                begin
                    bt = bt + 1'b1;
                end
                if (CMP_W'(bt) >= CMP_W'(blink_period_reg))
                begin
                    bt = '0;
                    pw = !pw;
                end
            end
            result_next.led_power = pw;
        end

        if (pu != '0)
        begin
            pu = pu - 1'b1;
        end

        phase_next       = ph;
        phase_timer_next = pt;
        pulse_timer_next = pu;
        blink_timer_next = bt;
        power_level_next = pw;
    end

`ifndef SYNTHESIS
    // once finished, the self-test never restarts
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("self-test left the done phase");

    // state moves only with an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(phase_reg) && $stable(pulse_timer_reg) &&
                      $stable(blink_timer_reg)))
        else $error("sequencer state changed without an item");

    // a held input item is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input item lost while stalled");

    // an acknowledged pulse with nonzero length lights the collection LED
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.pulse_ack && pulse_time_reg != '0)
            |-> out_data_reg.led_collect)
        else $error("acknowledged pulse did not light the collection LED");
`endif

endmodule

`default_nettype wire
